@@ rtl/pcd_pkg.sv @@
// Package for the PNG chunk deframer: parser phases, result kinds, the result record
// and the text sanitising function. Depends on nothing; pcd_walker and the top level import it.
`default_nettype none

package pcd_pkg;

    // Parser phase, one code per part of the file being walked.
    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5,
        PH_HALT = 3'd6
    } t_phase;

    // Kind of a result record.
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_BADSIG = 2'd2
    } t_kind;

    // One result record as it leaves the parser.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] chunk_offset;
        logic [31:0] chunk_length;
        logic [31:0] chunk_type;
        logic        is_text;
        logic        is_end;
        logic [7:0]  text_byte;
        logic        last_text;
    } t_result;

    // Field counter limits: the signature has eight bytes, the other fields four.
    localparam logic [2:0] SIG_LAST   = 3'd7;
    localparam logic [2:0] FIELD_LAST = 3'd3;

    // PNG file signature, indexed by byte position.
    localparam logic [7:0] PNG_SIG [8] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    // Chunk type codes, first character most significant.
    localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
    localparam logic [31:0] TYPE_ZTXT = 32'h7A54_5874;
    localparam logic [31:0] TYPE_ITXT = 32'h6954_5874;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // Characters touched by sanitising.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // True for the three textual chunk types.
    function automatic logic is_text_type(input logic [31:0] chunk_type);
        return (chunk_type == TYPE_TEXT) || (chunk_type == TYPE_ZTXT) ||
               (chunk_type == TYPE_ITXT);
    endfunction

    // Newline and NUL become a space, a double quote becomes a single quote.
    function automatic logic [7:0] sanitise(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c == CH_LF) || (c == CH_NUL)) begin
            r = CH_SPACE;
        end else if (c == CH_DQUOTE) begin
            r = CH_SQUOTE;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pcd_if.sv @@
// Valid/ready channel interfaces of the PNG chunk deframer: the byte input and the result output.
// Depends on nothing; the top level takes one of each.
`default_nettype none

// Input channel: one file byte a beat.
interface pcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       file_start;

    modport source (output valid, output byte_in, output file_start, input ready);
    modport sink   (input valid, input byte_in, input file_start, output ready);
endinterface

// Output channel: one result record a beat.
interface pcd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic        is_text;
    logic        is_end;
    logic [7:0]  text_byte;
    logic        last_text;

    modport source (output valid, output kind, output chunk_offset, output chunk_length,
                    output chunk_type, output is_text, output is_end, output text_byte,
                    output last_text, input ready);
    modport sink   (input valid, input kind, input chunk_offset, input chunk_length,
                    input chunk_type, input is_text, input is_end, input text_byte,
                    input last_text, output ready);
endinterface

`default_nettype wire

@@ rtl/pcd_walker.sv @@
// Chunk walker of the PNG chunk deframer: parser state and the result of each byte.
// Depends on pcd_pkg.
`default_nettype none

module pcd_walker
    import pcd_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic    i_file_start,
    output logic         o_has_result,
    output t_result      o_result
);

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_field_count, n_field_count;
    logic [31:0]            r_length_acc, n_length_acc;
    logic [31:0]            r_type_acc, n_type_acc;
    logic [31:0]            r_data_left, n_data_left;
    logic [OFFSET_BITS-1:0] r_byte_offset, n_byte_offset;
    logic [31:0]            r_chunk_start, n_chunk_start;
    logic                   r_text_flag, n_text_flag;

    // State as seen by this byte: a file start restarts from the reset values.
    t_phase                 cur_phase;
    logic [2:0]             cur_field_count;
    logic [31:0]            cur_length_acc;
    logic [31:0]            cur_type_acc;
    logic [31:0]            cur_data_left;
    logic [OFFSET_BITS-1:0] cur_pos;
    logic [31:0]            cur_chunk_start;
    logic                   cur_text_flag;
    logic [63:0]            pos_wide;

    // State register, advanced once for each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SIG;
            r_field_count <= '0;
            r_length_acc  <= '0;
            r_type_acc    <= '0;
            r_data_left   <= '0;
            r_byte_offset <= '0;
            r_chunk_start <= '0;
            r_text_flag   <= 1'b0;
        end else if (i_take) begin
            r_phase       <= n_phase;
            r_field_count <= n_field_count;
            r_length_acc  <= n_length_acc;
            r_type_acc    <= n_type_acc;
            r_data_left   <= n_data_left;
            r_byte_offset <= n_byte_offset;
            r_chunk_start <= n_chunk_start;
            r_text_flag   <= n_text_flag;
        end
    end

    // Next state and result for the byte on offer.
    always_comb begin
        cur_phase       = i_file_start ? PH_SIG : r_phase;
        cur_field_count = i_file_start ? 3'd0 : r_field_count;
        cur_length_acc  = i_file_start ? 32'd0 : r_length_acc;
        cur_type_acc    = i_file_start ? 32'd0 : r_type_acc;
        cur_data_left   = i_file_start ? 32'd0 : r_data_left;
        cur_pos         = i_file_start ? '0 : r_byte_offset;
        cur_chunk_start = i_file_start ? 32'd0 : r_chunk_start;
        cur_text_flag   = i_file_start ? 1'b0 : r_text_flag;
        pos_wide        = 64'(cur_pos);

        n_phase       = cur_phase;
        n_field_count = cur_field_count;
        n_length_acc  = cur_length_acc;
        n_type_acc    = cur_type_acc;
        n_data_left   = cur_data_left;
        n_byte_offset = cur_pos + OFFSET_BITS'(1);
        n_chunk_start = cur_chunk_start;
        n_text_flag   = cur_text_flag;

        o_has_result = 1'b0;
        o_result     = '0;

        unique case (cur_phase)
            PH_SIG: begin
                if (i_byte != PNG_SIG[cur_field_count]) begin
                    n_phase         = PH_HALT;
                    n_field_count   = 3'd0;
                    o_has_result    = 1'b1;
                    o_result.kind   = KIND_BADSIG;
                end else if (cur_field_count == SIG_LAST) begin
                    n_field_count = 3'd0;
                    n_phase       = PH_LEN;
                end else begin
                    n_field_count = cur_field_count + 3'd1;
                end
            end
            PH_LEN: begin
                if (cur_field_count == 3'd0) begin
                    n_chunk_start = pos_wide[31:0];
                end
                n_length_acc = {cur_length_acc[23:0], i_byte};
                if (cur_field_count == FIELD_LAST) begin
                    n_field_count = 3'd0;
                    n_phase       = PH_TYPE;
                end else begin
                    n_field_count = cur_field_count + 3'd1;
                end
            end
            PH_TYPE: begin
                n_type_acc = {cur_type_acc[23:0], i_byte};
                if (cur_field_count != FIELD_LAST) begin
                    n_field_count = cur_field_count + 3'd1;
                end else begin
                    n_field_count = 3'd0;
                    n_text_flag   = is_text_type(n_type_acc);
                    n_data_left   = cur_length_acc;
                    if (n_type_acc == TYPE_IEND) begin
                        n_phase = PH_DONE;
                    end else if (cur_length_acc == 32'd0) begin
                        n_phase = PH_CRC;
                    end else begin
                        n_phase = PH_DATA;
                    end
                    o_has_result          = 1'b1;
                    o_result.kind         = KIND_HEADER;
                    o_result.chunk_offset = cur_chunk_start;
                    o_result.chunk_length = cur_length_acc;
                    o_result.chunk_type   = n_type_acc;
                    o_result.is_text      = n_text_flag;
                    o_result.is_end       = (n_type_acc == TYPE_IEND);
                end
            end
            PH_DATA: begin
                n_data_left = cur_data_left - 32'd1;
                if (n_data_left == 32'd0) begin
                    n_phase = PH_CRC;
                end
                if (cur_text_flag) begin
                    o_has_result          = 1'b1;
                    o_result.kind         = KIND_TEXT;
                    o_result.chunk_offset = cur_chunk_start;
                    o_result.chunk_length = cur_length_acc;
                    o_result.chunk_type   = cur_type_acc;
                    o_result.is_text      = 1'b1;
                    o_result.is_end       = (cur_type_acc == TYPE_IEND);
                    o_result.text_byte    = sanitise(i_byte);
                    o_result.last_text    = (n_data_left == 32'd0);
                end
            end
            PH_CRC: begin
                if (cur_field_count == FIELD_LAST) begin
                    n_field_count = 3'd0;
                    n_phase       = PH_LEN;
                end else begin
                    n_field_count = cur_field_count + 3'd1;
                end
            end
            PH_DONE, PH_HALT: begin
                // Bytes are swallowed until the next file start.
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/png_chunk_deframer.sv @@
// Top level of the PNG chunk deframer: byte channel in, result channel out, two-entry result
// buffer. Depends on pcd_pkg, pcd_if (channel interfaces) and pcd_walker.
//
//  Channel    Dir  Beat                              Rate
//  i_byte     in   one file byte, file start flag    up to one beat per cycle
//  o_result   out  one header, text or error record  at most one per input beat
//
// Each byte is parsed in the cycle it is accepted and its record, if any, is registered at
// that edge. The record appears on o_result in the cycle after its byte when the main register
// is free, and later when it has to wait behind a held record. A byte can be taken every
// cycle: i_byte.ready falls only when both result registers are full, which the two-entry
// buffer behind the walker sets. Reset is synchronous on i_rst_n; a set file start flag
// restarts the parser with that byte as byte 0 of a new file.
`default_nettype none

module png_chunk_deframer
    import pcd_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    pcd_byte_if.sink       i_byte,
    pcd_result_if.source   o_result
);

    logic    take;
    logic    has_result;
    logic    push;
    logic    pop;
    t_result new_result;

    // Main output register and the skid register behind it.
    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    assign i_byte.ready = !r_skid_valid;
    assign take         = i_byte.valid && i_byte.ready;
    assign push         = take && has_result;
    assign pop          = r_main_valid && o_result.ready;

    pcd_walker #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_byte       (i_byte.byte_in),
        .i_file_start (i_byte.file_start),
        .o_has_result (has_result),
        .o_result     (new_result)
    );

    // Valid flags of the result buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // Payload of the result buffer: a new record goes to the skid register only when
    // the main register is full and held.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (push) begin
            if (r_main_valid && !pop) begin
                r_skid <= new_result;
            end else begin
                r_main <= new_result;
            end
        end
    end

    // Output beat.
    assign o_result.valid        = r_main_valid;
    assign o_result.kind         = r_main.kind;
    assign o_result.chunk_offset = r_main.chunk_offset;
    assign o_result.chunk_length = r_main.chunk_length;
    assign o_result.chunk_type   = r_main.chunk_type;
    assign o_result.is_text      = r_main.is_text;
    assign o_result.is_end       = r_main.is_end;
    assign o_result.text_byte    = r_main.text_byte;
    assign o_result.last_text    = r_main.last_text;

endmodule

`default_nettype wire

@@ tb/sv/png_chunk_deframer_tb.sv @@
// Self-checking testbench for png_chunk_deframer: drives whole and broken PNG byte streams and
// checks every header, text and bad-signature record against a predictor of the chunk walker.
// Depends on pcd_pkg, pcd_if and the png_chunk_deframer top level.
`default_nettype none

module png_chunk_deframer_tb;
    import pcd_pkg::*;

    localparam int OFFSET_BITS = 32;
    localparam int CLK_PERIOD  = 20;
    localparam int TARGET_BYTES = 1550;
    localparam int WATCHDOG_CYCLES = 400000;

    // Receiver stall patterns.
    localparam int RX_FREE   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_EVERY3 = 2;
    localparam int RX_SPARSE = 3;

    // Signature bytes, first byte most significant.
    localparam logic [63:0] SIG_BYTES = 64'h8950_4E47_0D0A_1A0A;

    // A few non-text chunk types seen in real files.
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_file_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcd_byte_if   byte_ch ();
    pcd_result_if res_ch ();

    png_chunk_deframer #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (res_ch)
    );

    // Free-running clock.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_file_byte file_bytes[$];
    t_result    records_due[$];
    int         counted_bytes = 0;
    int         fail_count = 0;

    // Shadow copy of the walker state.
    t_phase                 ph;
    logic [2:0]             fcount;
    logic [31:0]            len_acc;
    logic [31:0]            typ_acc;
    logic [31:0]            left_cnt;
    logic [31:0]            chunk_at;
    logic [OFFSET_BITS-1:0] pos_cnt;
    logic                   txt;

    task automatic clear_parser();
        ph       = PH_SIG;
        fcount   = '0;
        len_acc  = '0;
        typ_acc  = '0;
        left_cnt = '0;
        chunk_at = '0;
        pos_cnt  = '0;
        txt      = 1'b0;
    endtask

    // Record that repeats the header of the current chunk.
    function automatic t_result chunk_record(input t_kind k, input logic [7:0] c,
                                             input logic last);
        t_result r;
        r.kind         = k;
        r.chunk_offset = chunk_at;
        r.chunk_length = len_acc;
        r.chunk_type   = typ_acc;
        r.is_text      = txt;
        r.is_end       = (typ_acc == TYPE_IEND);
        r.text_byte    = c;
        r.last_text    = last;
        return r;
    endfunction

    // Advance the shadow walker by one accepted byte and queue the record it causes.
    task automatic walk_byte(input logic [7:0] b, input logic fs);
        logic [31:0] pos;
        logic [7:0]  c;
        t_result     r;
        int          idx;
        if (fs) begin
            clear_parser();
        end
        pos = 32'(pos_cnt);
        pos_cnt = pos_cnt + OFFSET_BITS'(1);
        case (ph)
            PH_SIG: begin
                idx = 7 - int'(fcount);
                if (b != SIG_BYTES[8*idx +: 8]) begin
                    ph = PH_HALT;
                    fcount = '0;
                    r = '0;
                    r.kind = KIND_BADSIG;
                    records_due.push_back(r);
                end else if (fcount == SIG_LAST) begin
                    fcount = '0;
                    ph = PH_LEN;
                end else begin
                    fcount = fcount + 3'd1;
                end
            end
            PH_LEN: begin
                if (fcount == 3'd0) begin
                    chunk_at = pos;
                end
                len_acc = {len_acc[23:0], b};
                if (fcount == FIELD_LAST) begin
                    fcount = '0;
                    ph = PH_TYPE;
                end else begin
                    fcount = fcount + 3'd1;
                end
            end
            PH_TYPE: begin
                typ_acc = {typ_acc[23:0], b};
                if (fcount != FIELD_LAST) begin
                    fcount = fcount + 3'd1;
                end else begin
                    fcount = '0;
                    txt = (typ_acc == TYPE_TEXT) || (typ_acc == TYPE_ZTXT) ||
                          (typ_acc == TYPE_ITXT);
                    left_cnt = len_acc;
                    if (typ_acc == TYPE_IEND) begin
                        ph = PH_DONE;
                    end else if (left_cnt == 32'd0) begin
                        ph = PH_CRC;
                    end else begin
                        ph = PH_DATA;
                    end
                    records_due.push_back(chunk_record(KIND_HEADER, 8'h00, 1'b0));
                end
            end
            PH_DATA: begin
                left_cnt = left_cnt - 32'd1;
                if (left_cnt == 32'd0) begin
                    ph = PH_CRC;
                end
                if (txt) begin
                    c = b;
                    if ((c == CH_LF) || (c == CH_NUL)) begin
                        c = CH_SPACE;
                    end else if (c == CH_DQUOTE) begin
                        c = CH_SQUOTE;
                    end
                    records_due.push_back(chunk_record(KIND_TEXT, c, left_cnt == 32'd0));
                end
            end
            PH_CRC: begin
                if (fcount == FIELD_LAST) begin
                    fcount = '0;
                    ph = PH_LEN;
                end else begin
                    fcount = fcount + 3'd1;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Stream building. Bytes the block will ignore are not counted.
    task automatic add_byte(input logic [7:0] b, input logic fs, input logic live);
        t_file_byte it;
        it.data  = b;
        it.start = fs;
        file_bytes.push_back(it);
        if (live) begin
            counted_bytes++;
        end
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            add_byte(w[8*(3-i) +: 8], 1'b0, 1'b1);
        end
    endtask

    // Signature with file start on its first byte; a position below 8 is corrupted and ends it.
    task automatic add_signature(input int bad_at);
        logic [7:0] b;
        int         i;
        logic       stop;
        stop = 1'b0;
        for (i = 0; (i < 8) && !stop; i++) begin
            b = SIG_BYTES[8*(7-i) +: 8];
            if (i == bad_at) begin
                b = b ^ 8'($urandom_range(1, 255));
                stop = 1'b1;
            end
            add_byte(b, i == 0, 1'b1);
        end
    endtask

    // Data bytes lean towards the characters that sanitising touches.
    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return CH_LF;
            1:       return CH_NUL;
            2:       return CH_DQUOTE;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_type();
        case ($urandom_range(0, 7))
            0:       return TYPE_TEXT;
            1:       return TYPE_ZTXT;
            2:       return TYPE_ITXT;
            3:       return $urandom;
            4:       return TYPE_IHDR;
            5:       return TYPE_IDAT;
            6:       return TYPE_TEXT ^ (32'd1 << $urandom_range(0, 31));
            default: return TYPE_ITXT ^ (32'd1 << $urandom_range(0, 31));
        endcase
    endfunction

    task automatic add_chunk(input logic [31:0] typ, input logic [31:0] len);
        add_word(len);
        add_word(typ);
        for (int i = 0; i < int'(len); i++) begin
            add_byte(pick_data(), 1'b0, 1'b1);
        end
        add_word($urandom);
    endtask

    // One file: mostly well formed, some with a bad signature or cut short.
    task automatic add_file();
        int          sel;
        int          n;
        int          r;
        logic [31:0] len;
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
            add_signature(8);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 9);
                len = (r == 0) ? 32'd0 :
                      (r < 8)  ? 32'($urandom_range(1, 8)) : 32'($urandom_range(9, 40));
                add_chunk(pick_type(), len);
            end
            if ($urandom_range(0, 3) != 0) begin
                // IEND, then its data, CRC and trailing bytes, all ignored.
                len = 32'($urandom_range(0, 3));
                add_word(len);
                add_word(TYPE_IEND);
                n = int'(len) + 4 + $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    add_byte(8'($urandom), 1'b0, 1'b0);
                end
            end else begin
                // Cut off inside the next chunk header.
                n = $urandom_range(0, 7);
                for (int i = 0; i < n; i++) begin
                    add_byte(8'($urandom), 1'b0, 1'b1);
                end
            end
        end else if (sel == 8) begin
            add_signature($urandom_range(0, 7));
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                add_byte(8'($urandom), 1'b0, 1'b0);
            end
        end else begin
            // Chunk with a huge or random length, abandoned by the next file start.
            add_signature(8);
            len = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom;
            add_word(len);
            add_word(pick_type());
            n = $urandom_range(0, 20);
            for (int i = 0; i < n; i++) begin
                add_byte(pick_data(), 1'b0, 1'b1);
            end
        end
    endtask

    // Sender: bursts of beats separated by idle gaps, each gap starting after an accepted beat.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin : drive_bytes
        t_file_byte cur;
        logic       took;
        if (!i_rst_n) begin
            clear_parser();
            byte_ch.valid      <= 1'b0;
            byte_ch.byte_in    <= 8'h00;
            byte_ch.file_start <= 1'b0;
        end else begin
            took = byte_ch.valid && byte_ch.ready;
            if (took) begin
                cur = file_bytes.pop_front();
                walk_byte(cur.data, cur.start);
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (byte_ch.valid && !took) begin
                // Hold the beat until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                byte_ch.valid <= 1'b0;
            end else if (file_bytes.size() > 0) begin
                byte_ch.valid      <= 1'b1;
                byte_ch.byte_in    <= file_bytes[0].data;
                byte_ch.file_start <= file_bytes[0].start;
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compare one accepted result beat with the oldest record due.
    task automatic check_record();
        t_result want;
        if (records_due.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual kind %h type %h",
                     $time, res_ch.kind, res_ch.chunk_type);
        end else begin
            want = records_due.pop_front();
            report_field("kind", 32'(want.kind), 32'(res_ch.kind));
            report_field("chunk_offset", want.chunk_offset, res_ch.chunk_offset);
            report_field("chunk_length", want.chunk_length, res_ch.chunk_length);
            report_field("chunk_type", want.chunk_type, res_ch.chunk_type);
            report_field("is_text", 32'(want.is_text), 32'(res_ch.is_text));
            report_field("is_end", 32'(want.is_end), 32'(res_ch.is_end));
            report_field("text_byte", 32'(want.text_byte), 32'(res_ch.text_byte));
            report_field("last_text", 32'(want.last_text), 32'(res_ch.last_text));
        end
    endtask

    // Receiver: checks each beat and stalls on one of four patterns, picked anew at random.
    int rx_mode = RX_FREE;
    int mode_left = 0;
    int rx_tick = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            mode_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                check_record();
            end
            if (mode_left == 0) begin
                rx_mode = $urandom_range(RX_FREE, RX_SPARSE);
                mode_left = $urandom_range(40, 240);
            end else begin
                mode_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_FREE:   res_ch.ready <= 1'b1;
                RX_RANDOM: res_ch.ready <= ($urandom_range(0, 9) < 7);
                RX_EVERY3: res_ch.ready <= ((rx_tick % 3) == 0);
                default:   res_ch.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.byte_in    = 8'h00;
        byte_ch.file_start = 1'b0;
        res_ch.ready       = 1'b0;

        // Directed: a bad first byte straight after reset, then a text chunk whose data
        // holds a newline, a NUL, a double quote and an all-ones byte.
        add_byte(8'hFF, 1'b0, 1'b1);
        add_signature(8);
        add_word(32'd4);
        add_word(TYPE_TEXT);
        add_byte(CH_LF, 1'b0, 1'b1);
        add_byte(CH_NUL, 1'b0, 1'b1);
        add_byte(CH_DQUOTE, 1'b0, 1'b1);
        add_byte(8'hFF, 1'b0, 1'b1);
        add_word(32'h0000_0000);

        while (counted_bytes < TARGET_BYTES) begin
            add_file();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((file_bytes.size() != 0) || (records_due.size() != 0)) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
